// ----- src/dhp_pkg.sv -----
// Shared types and constants for the difference hash packer.
`timescale 1ns / 1ps
package dhp_pkg;

  localparam int SIDE_W    = 5;
  localparam int PIX_W     = 8;
  localparam int BYTE_BITS = 8;
  localparam int MIN_SIDE  = 4;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } dhp_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic start_col;
    logic bit_step;
    logic emit;
  } dhp_cmd_t;

  typedef struct packed {
    logic grid_last;
    logic byte_full;
    logic pass_end;
    logic col_pass;
    logic out_free;
  } dhp_sts_t;

endpackage

// ----- src/difference_hash_packer.sv -----
// Difference hash packer: stores a pixel grid, then streams row and column hash bytes.
// Grid load: one pixel per cycle, (S+1)^2 transactions per grid, S the clamped side.
// Burst: each comparison bit takes a read state (memory read of both pixels), then a
//   compare state; after every eighth bit an emit state registers the byte and waits
//   while out_tready stalls. Input stalls during the burst.
// Reset: control cleared, side min(8, MAX_SIDE), pixel memory undefined (not cleared).
`timescale 1ns / 1ps
module difference_hash_packer #(
  parameter int MAX_SIDE = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dhp_pkg::PIX_W-1:0]     in_tdata,   // [7:0] pixel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dhp_pkg::BYTE_BITS-1:0] out_tdata,  // [7:0] hash_byte
  output logic                          out_tlast,  // last_byte
  input  logic                          cfg_we,
  input  logic [dhp_pkg::SIDE_W-1:0]    cfg_wdata   // hash_side
);
  import dhp_pkg::*;

  dhp_cmd_t cmd;
  dhp_sts_t sts;

  dhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dhp_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pixel   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/dhp_ctrl.sv -----
// Controller state machine: grid load, two comparison passes, byte emission.
`timescale 1ns / 1ps
module dhp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dhp_pkg::dhp_sts_t sts,
  output dhp_pkg::dhp_cmd_t cmd
);
  import dhp_pkg::*;

  dhp_state_t state_r, state_nxt;
  logic       pass_end_r, pass_end_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      pass_end_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pass_end_r <= pass_end_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    pass_end_nxt = pass_end_r;
    in_tready    = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.grid_last) begin
            cmd.start = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.bit_step = 1'b1;
        pass_end_nxt = sts.pass_end;
        if (sts.byte_full) begin
          state_nxt = ST_EMIT;
        end else if (sts.pass_end) begin
          if (sts.col_pass) begin
            state_nxt = ST_LOAD;
          end else begin
            cmd.start     = 1'b1;
            cmd.start_col = 1'b1;
            state_nxt     = ST_READ;
          end
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (pass_end_r) begin
            if (sts.col_pass) begin
              state_nxt = ST_LOAD;
            end else begin
              cmd.start     = 1'b1;
              cmd.start_col = 1'b1;
              state_nxt     = ST_READ;
            end
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

// ----- src/dhp_datapath.sv -----
// Datapath: pixel memory, address walk, comparator, bit packer and output register.
`timescale 1ns / 1ps
module dhp_datapath #(
  parameter int MAX_SIDE = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dhp_pkg::PIX_W-1:0]  in_pixel,
  input  logic                       cfg_we,
  input  logic [dhp_pkg::SIDE_W-1:0] cfg_wdata,
  input  dhp_pkg::dhp_cmd_t          cmd,
  output dhp_pkg::dhp_sts_t          sts,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dhp_pkg::BYTE_BITS-1:0] out_tdata,
  output logic                       out_tlast
);
  import dhp_pkg::*;

  localparam int DEPTH      = (MAX_SIDE + 1) * (MAX_SIDE + 1);
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(MAX_SIDE);
  localparam int BW         = $clog2(MAX_SIDE * MAX_SIDE / BYTE_BITS + 1);
  localparam int RESET_SIDE = (MAX_SIDE < 8) ? MAX_SIDE : 8;
  localparam int CNT_W      = $clog2(BYTE_BITS);

  logic [PIX_W-1:0]     mem [DEPTH];
  logic [PIX_W-1:0]     rd_a_r, rd_b_r;

  logic [SIDE_W-1:0]    side_r;
  logic [AW-1:0]        count_r;
  logic                 col_r;
  logic                 out_tvalid_r;

  logic [AW-1:0]        a_r;
  logic [CW-1:0]        i_r, j_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [BYTE_BITS-1:0] acc_r;
  logic [BW-1:0]        byte_idx_r;
  logic [BYTE_BITS-1:0] out_tdata_r;
  logic                 out_tlast_r;

  logic [SIDE_W-1:0]    side_clamp;
  logic [CW-1:0]        side_m1;
  logic [AW-1:0]        width;
  logic [AW-1:0]        addr_b;
  logic [9:0]           grid_full;
  logic [9:0]           side_sq;
  logic [AW-1:0]        grid_m1;
  logic [BW-1:0]        nbytes_m1;

  always_comb begin
    if (cfg_wdata < SIDE_W'(MIN_SIDE)) begin
      side_clamp = SIDE_W'(MIN_SIDE);
    end else if (cfg_wdata > SIDE_W'(MAX_SIDE)) begin
      side_clamp = SIDE_W'(MAX_SIDE);
    end else begin
      side_clamp = cfg_wdata;
    end
  end

  assign side_m1   = CW'(side_r - SIDE_W'(1));
  assign width     = AW'(side_r) + AW'(1);
  assign addr_b    = a_r + (col_r ? width : AW'(1));
  assign grid_full = (10'(side_r) + 10'd1) * (10'(side_r) + 10'd1) - 10'd1;
  assign grid_m1   = AW'(grid_full);
  assign side_sq   = 10'(side_r) * 10'(side_r);
  assign nbytes_m1 = BW'((side_sq >> 3) - 10'd1);

  assign sts.grid_last = (count_r == grid_m1);
  assign sts.byte_full = (cnt_r == CNT_W'(BYTE_BITS - 1));
  assign sts.pass_end  = (i_r == side_m1) && (j_r == side_m1);
  assign sts.col_pass  = col_r;
  assign sts.out_free  = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[count_r] <= in_pixel;
    end
    rd_a_r <= mem[a_r];
    rd_b_r <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r       <= SIDE_W'(RESET_SIDE);
      count_r      <= '0;
      col_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        side_r  <= side_clamp;
        count_r <= '0;
      end else if (cmd.load) begin
        count_r <= sts.grid_last ? '0 : count_r + AW'(1);
      end
      if (cmd.start) begin
        col_r <= cmd.start_col;
      end
      if (cmd.emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r   <= '0;
      i_r   <= '0;
      j_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.bit_step) begin
      acc_r <= {acc_r[BYTE_BITS-2:0], (rd_a_r < rd_b_r)};
      cnt_r <= cnt_r + CNT_W'(1);
      if (j_r == side_m1) begin
        j_r <= '0;
        i_r <= i_r + CW'(1);
        a_r <= col_r ? (AW'(i_r) + AW'(1)) : (a_r + AW'(2));
      end else begin
        j_r <= j_r + CW'(1);
        a_r <= col_r ? (a_r + width) : (a_r + AW'(1));
      end
    end
    if (cmd.emit) begin
      out_tdata_r <= acc_r;
      out_tlast_r <= col_r && (byte_idx_r == nbytes_m1);
    end
    if (cmd.start) begin
      byte_idx_r <= '0;
    end else if (cmd.emit) begin
      byte_idx_r <= byte_idx_r + BW'(1);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ----- src/dhp_checker.sv -----
// Port-level checks for the difference hash packer, bound to the top level.
`timescale 1ns / 1ps
module dhp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [dhp_pkg::BYTE_BITS-1:0] out_tdata,
  input logic                          out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_load_only_after_hash: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("pixel accepted while hash burst incomplete");

  a_nothing_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("byte emitted after final hash byte");

endmodule

bind difference_hash_packer dhp_checker u_dhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- sim/tb_difference_hash_packer.sv -----
// Self-checking testbench for difference_hash_packer: random grids, side settings, stalls.
`timescale 1ns / 1ps
module tb_difference_hash_packer;

  localparam int MAX_SIDE   = 16;
  localparam int STORE_SIZE = (MAX_SIDE + 1) * (MAX_SIDE + 1);
  localparam int SETTLE_CYC = 60;
  localparam int HOLD_CYC   = 300;

  typedef struct packed {
    logic [dhp_pkg::BYTE_BITS-1:0] hash_byte;
    logic                          last_byte;
  } hash_result_t;

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [dhp_pkg::PIX_W-1:0]     in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [dhp_pkg::BYTE_BITS-1:0] out_tdata;
  logic                          out_tlast;
  logic                          cfg_we     = 1'b0;
  logic [dhp_pkg::SIDE_W-1:0]    cfg_wdata  = '0;

  // predictor state
  logic [dhp_pkg::SIDE_W-1:0] side_model = 5'd8;
  logic [dhp_pkg::PIX_W-1:0]  grid_store [STORE_SIZE];
  int                         grid_fill = 0;
  hash_result_t               hash_expect_q [$];
  logic [dhp_pkg::PIX_W-1:0]  pixel_queue [$];

  int  pixels_queued   = 0;
  int  pixels_accepted = 0;
  int  grids_hashed    = 0;
  int  bytes_checked   = 0;
  int  side_writes     = 0;
  int  fail_count      = 0;
  int  in_gap          = 0;
  int  out_gap         = 0;
  int  hold_left       = 0;
  bit  hold_used       = 1'b0;
  bit  hold_armed      = 1'b0;
  bit  idle_en         = 1'b1;
  logic [dhp_pkg::PIX_W-1:0] last_pix = '0;

  difference_hash_packer #(
    .MAX_SIDE(MAX_SIDE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_side(input logic [dhp_pkg::SIDE_W-1:0] v);
    if (v < dhp_pkg::MIN_SIDE) return dhp_pkg::MIN_SIDE;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic void pack_pass(input int s, input bit row_major, input int total,
                                    inout int idx);
    int w;
    int step;
    int a;
    int cnt;
    logic [dhp_pkg::BYTE_BITS-1:0] acc;
    hash_result_t exp_item;
    w    = s + 1;
    step = row_major ? 1 : w;
    cnt  = 0;
    acc  = '0;
    for (int i = 0; i < s; i++) begin
      for (int j = 0; j < s; j++) begin
        a   = row_major ? (i * w + j) : (j * w + i);
        acc = {acc[dhp_pkg::BYTE_BITS-2:0], grid_store[a] < grid_store[a + step]};
        cnt++;
        if (cnt == dhp_pkg::BYTE_BITS) begin
          exp_item.hash_byte = acc;
          exp_item.last_byte = (idx == total - 1);
          hash_expect_q.insert(hash_expect_q.size(), exp_item);
          idx++;
          cnt = 0;
          acc = '0;
        end
      end
    end
  endfunction

  function automatic void take_pixel(input logic [dhp_pkg::PIX_W-1:0] px);
    int s;
    int total;
    int idx;
    s = clamp_side(side_model);
    grid_store[grid_fill] = px;
    grid_fill++;
    if (grid_fill >= (s + 1) * (s + 1)) begin
      grid_fill = 0;
      total = 2 * ((s * s) / dhp_pkg::BYTE_BITS);
      idx   = 0;
      pack_pass(s, 1'b1, total, idx);
      pack_pass(s, 1'b0, total, idx);
      grids_hashed++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_pixel(in_tdata);
        pixels_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_queue.pop_front();
          if (idle_en && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    hash_result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (hash_expect_q.size() == 0) begin
          $display("%0t: unexpected transaction: actual byte %02h last %0b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          exp_r = hash_expect_q.pop_front();
          bytes_checked++;
          if (out_tdata !== exp_r.hash_byte) begin
            $display("%0t: hash_byte mismatch: expected %02h actual %02h",
                     $time, exp_r.hash_byte, out_tdata);
            fail_count++;
          end
          if (out_tlast !== exp_r.last_byte) begin
            $display("%0t: last_byte mismatch: expected %0b actual %0b",
                     $time, exp_r.last_byte, out_tlast);
            fail_count++;
          end
        end
      end
      if (hold_armed && !hold_used && out_tvalid) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 3);
      end
    end
  end

  function automatic logic [dhp_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return last_pix;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_pixel(input logic [dhp_pkg::PIX_W-1:0] px);
    pixel_queue.insert(pixel_queue.size(), px);
    last_pix = px;
    pixels_queued++;
  endtask

  task automatic queue_grids(input int n_grids, input int partial);
    int s;
    s = clamp_side(side_model);
    repeat (n_grids * (s + 1) * (s + 1) + partial) queue_pixel(pick_pixel());
  endtask

  task automatic settle();
    while (pixels_accepted != pixels_queued) @(posedge clk);
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_side(input logic [dhp_pkg::SIDE_W-1:0] v);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    side_model  = v;
    grid_fill   = 0;
    side_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic side_phase(input logic [dhp_pkg::SIDE_W-1:0] v, input int n_grids,
                            input int partial);
    settle();
    write_side(v);
    queue_grids(n_grids, partial);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset side: extremes, equal run and a ramp in the first rows, rest random
    for (int k = 0; k < 27; k++) begin
      if (k < 9) queue_pixel((k % 2) ? 8'hFF : 8'h00);
      else if (k < 18) queue_pixel(8'h80);
      else queue_pixel(8'(8'hFF - (k - 18) * 31));
    end
    repeat (81 - 27) queue_pixel(pick_pixel());

    // side below range, long receiver hold while the next grid waits
    settle();
    write_side(5'd0);
    hold_armed = 1'b1;
    queue_grids(2, 7);

    side_phase(5'd5, 1, 11);
    side_phase(5'd6, 1, 0);

    settle();
    idle_en = 1'b0;
    write_side(5'd3);
    queue_grids(1, 0);
    settle();

    $display("run: %0d pixels, %0d grids, %0d side writes, %0d hash bytes checked",
             pixels_accepted, grids_hashed, side_writes, bytes_checked);
    if (hash_expect_q.size() != 0) begin
      $display("%0t: %0d expected hash bytes never arrived", $time, hash_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
